// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PAP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pack index parser assertion failed");

// Next-cycle implication, quiet during reset.
`define PAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pack index parser assertion failed");

`endif

// ===== design/pap_pkg.sv =====
// Package for the pack archive index parser: phase and result codes,
// header constants and the result word type. No dependencies.
package pap_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DEPS   = 3'd2,
        PH_FSIZE  = 3'd3,
        PH_FPATH  = 3'd4,
        PH_DONE   = 3'd5,
        PH_HALT   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_DEP_CHAR  = 3'd1,
        KIND_DEP_END   = 3'd2,
        KIND_PATH_CHAR = 3'd3,
        KIND_ENTRY     = 3'd4,
        KIND_BAD_MAGIC = 3'd5
    } kind_t;

    localparam logic [31:0] MAGIC_V0   = 32'h3048_4650;  // "PFH0" little-endian
    localparam logic [31:0] MAGIC_V2   = 32'h3248_4650;  // "PFH2" little-endian
    localparam logic [5:0]  HDR_LEN_V0 = 6'd24;
    localparam logic [5:0]  HDR_LEN_V2 = 6'd32;

    // last byte of each header word
    localparam logic [4:0] HB_MAGIC      = 5'd3;
    localparam logic [4:0] HB_TYPE       = 5'd7;
    localparam logic [4:0] HB_DEP_COUNT  = 5'd11;
    localparam logic [4:0] HB_DEP_SIZE   = 5'd15;
    localparam logic [4:0] HB_FILE_COUNT = 5'd19;
    localparam logic [4:0] HB_FILE_SIZE  = 5'd23;
    localparam logic [4:0] HB_V2_LAST    = 5'd31;

    localparam logic [1:0] SB_LAST = 2'd3;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  char_out;
        logic        version;
        logic [31:0] archive_type;
        logic [31:0] dep_count;
        logic [31:0] file_count;
        logic [31:0] entry_size;
        logic [63:0] entry_offset;
        logic [31:0] entry_index;
    } result_t;

endpackage

// ===== design/pap_core.sv =====
// Parser state and per-byte step logic for the pack archive index parser.
// Depends on pap_pkg.
module pap_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       byte_in,
    input  logic             start_req,
    output pap_pkg::result_t res
);
    import pap_pkg::*;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [4:0]  hb_reg, hb_next, cur_hb;
    logic [31:0] word_reg, word_next, cur_word, word_new;
    logic        v2_reg, v2_next, cur_v2;
    logic [31:0] type_reg, type_next, cur_type;
    logic [31:0] deps_total_reg, deps_total_next, cur_deps_total;
    logic [31:0] deps_bytes_reg, deps_bytes_next, cur_deps_bytes;
    logic [31:0] files_total_reg, files_total_next, cur_files_total;
    logic [31:0] files_bytes_reg, files_bytes_next, cur_files_bytes;
    logic [31:0] region_reg, region_next, cur_region, region_inc;
    logic [31:0] item_reg, item_next, cur_item, item_inc;
    logic [1:0]  sb_reg, sb_next, cur_sb;
    logic [63:0] offset_reg, offset_next, cur_offset;
    logic [5:0]  hdr_len;
    logic        bad_magic;

    always_comb
    begin
        // a start byte sees the reset state
        cur_phase       = start_req ? PH_HEADER : phase_reg;
        cur_hb          = start_req ? 5'd0  : hb_reg;
        cur_word        = start_req ? 32'd0 : word_reg;
        cur_v2          = start_req ? 1'b0  : v2_reg;
        cur_type        = start_req ? 32'd0 : type_reg;
        cur_deps_total  = start_req ? 32'd0 : deps_total_reg;
        cur_deps_bytes  = start_req ? 32'd0 : deps_bytes_reg;
        cur_files_total = start_req ? 32'd0 : files_total_reg;
        cur_files_bytes = start_req ? 32'd0 : files_bytes_reg;
        cur_region      = start_req ? 32'd0 : region_reg;
        cur_item        = start_req ? 32'd0 : item_reg;
        cur_sb          = start_req ? 2'd0  : sb_reg;
        cur_offset      = start_req ? 64'd0 : offset_reg;

        phase_next       = cur_phase;
        hb_next          = cur_hb;
        word_next        = cur_word;
        v2_next          = cur_v2;
        type_next        = cur_type;
        deps_total_next  = cur_deps_total;
        deps_bytes_next  = cur_deps_bytes;
        files_total_next = cur_files_total;
        files_bytes_next = cur_files_bytes;
        region_next      = cur_region;
        item_next        = cur_item;
        sb_next          = cur_sb;
        offset_next      = cur_offset;

        region_inc = cur_region + 32'd1;
        item_inc   = cur_item + 32'd1;
        word_new   = cur_word;
        hdr_len    = HDR_LEN_V0;
        bad_magic  = 1'b0;
        res        = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_hb[1:0] == 2'd0)
                    word_new = {24'd0, byte_in};
                else
                    word_new = cur_word | ({24'd0, byte_in} << {cur_hb[1:0], 3'b000});
                word_next = word_new;
                if (cur_hb == HB_MAGIC)
                begin
                    if (word_new == MAGIC_V0)
                        v2_next = 1'b0;
                    else if (word_new == MAGIC_V2)
                        v2_next = 1'b1;
                    else
                        bad_magic = 1'b1;
                end
                if (bad_magic)
                begin
                    phase_next = PH_HALT;
                    res.valid  = 1'b1;
                    res.kind   = KIND_BAD_MAGIC;
                end
                else
                begin
                    if (cur_hb == HB_TYPE)       type_next        = word_new;
                    if (cur_hb == HB_DEP_COUNT)  deps_total_next  = word_new;
                    if (cur_hb == HB_DEP_SIZE)   deps_bytes_next  = word_new;
                    if (cur_hb == HB_FILE_COUNT) files_total_next = word_new;
                    if (cur_hb == HB_FILE_SIZE)  files_bytes_next = word_new;
                    if ((cur_hb == HB_FILE_SIZE && !v2_next) || cur_hb == HB_V2_LAST)
                    begin
                        hdr_len     = v2_next ? HDR_LEN_V2 : HDR_LEN_V0;
                        offset_next = {58'd0, hdr_len} + {32'd0, deps_bytes_next}
                                      + {32'd0, files_bytes_next};
                        res.valid        = 1'b1;
                        res.kind         = KIND_HEADER;
                        res.version      = v2_next;
                        res.archive_type = type_next;
                        res.dep_count    = deps_total_next;
                        res.file_count   = files_total_next;
                        hb_next     = 5'd0;
                        region_next = 32'd0;
                        item_next   = 32'd0;
                        if (deps_bytes_next == 32'd0)
                        begin
                            sb_next   = 2'd0;
                            word_next = 32'd0;
                            if (files_total_next == 32'd0 || files_bytes_next == 32'd0)
                                phase_next = PH_DONE;
                            else
                                phase_next = PH_FSIZE;
                        end
                        else
                            phase_next = PH_DEPS;
                    end
                    else
                        hb_next = cur_hb + 5'd1;
                end
            end
            PH_DEPS:
            begin
                // names past the dependency count are consumed silently
                if (cur_item < cur_deps_total)
                begin
                    res.valid       = 1'b1;
                    res.entry_index = cur_item;
                    if (byte_in == CHAR_NUL)
                    begin
                        res.kind  = KIND_DEP_END;
                        item_next = item_inc;
                    end
                    else
                    begin
                        res.kind     = KIND_DEP_CHAR;
                        res.char_out = byte_in;
                    end
                end
                region_next = region_inc;
                if (region_inc == cur_deps_bytes)
                begin
                    region_next = 32'd0;
                    item_next   = 32'd0;
                    sb_next     = 2'd0;
                    word_next   = 32'd0;
                    if (cur_files_total == 32'd0 || cur_files_bytes == 32'd0)
                        phase_next = PH_DONE;
                    else
                        phase_next = PH_FSIZE;
                end
            end
            PH_FSIZE:
            begin
                if (cur_sb == 2'd0)
                    word_next = {24'd0, byte_in};
                else
                    word_next = cur_word | ({24'd0, byte_in} << {cur_sb, 3'b000});
                if (cur_sb == SB_LAST)
                begin
                    // leading slash of the path
                    phase_next      = PH_FPATH;
                    res.valid       = 1'b1;
                    res.kind        = KIND_PATH_CHAR;
                    res.char_out    = CHAR_SLASH;
                    res.entry_index = cur_item;
                end
                sb_next     = cur_sb + 2'd1;
                region_next = region_inc;
                if (region_inc == cur_files_bytes)
                    phase_next = PH_DONE;
            end
            PH_FPATH:
            begin
                region_next     = region_inc;
                res.valid       = 1'b1;
                res.entry_index = cur_item;
                if (byte_in == CHAR_NUL)
                begin
                    res.kind         = KIND_ENTRY;
                    res.entry_size   = cur_word;
                    res.entry_offset = cur_offset;
                    offset_next      = cur_offset + {32'd0, cur_word};
                    item_next        = item_inc;
                    sb_next          = 2'd0;
                    phase_next       = (item_inc == cur_files_total) ? PH_DONE : PH_FSIZE;
                end
                else
                begin
                    res.kind     = KIND_PATH_CHAR;
                    res.char_out = (byte_in == CHAR_BSLASH) ? CHAR_SLASH : byte_in;
                end
                if (region_inc == cur_files_bytes)
                    phase_next = PH_DONE;
            end
            default:
            begin
                // done or halted: drop the byte
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hb_reg          <= 5'd0;
            word_reg        <= 32'd0;
            v2_reg          <= 1'b0;
            type_reg        <= 32'd0;
            deps_total_reg  <= 32'd0;
            deps_bytes_reg  <= 32'd0;
            files_total_reg <= 32'd0;
            files_bytes_reg <= 32'd0;
            region_reg      <= 32'd0;
            item_reg        <= 32'd0;
            sb_reg          <= 2'd0;
            offset_reg      <= 64'd0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            hb_reg          <= hb_next;
            word_reg        <= word_next;
            v2_reg          <= v2_next;
            type_reg        <= type_next;
            deps_total_reg  <= deps_total_next;
            deps_bytes_reg  <= deps_bytes_next;
            files_total_reg <= files_total_next;
            files_bytes_reg <= files_bytes_next;
            region_reg      <= region_next;
            item_reg        <= item_next;
            sb_reg          <= sb_next;
            offset_reg      <= offset_next;
        end
    end

endmodule

// ===== design/pack_archive_index_parser.sv =====
// Top level of the pack archive index parser: input byte register, parser
// core and result register. Depends on pap_pkg and pap_core.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  input   | byte_valid / byte_stall    | byte_in, start_req
//  result  | result_valid / result_stall| kind, char_out, version, archive_type,
//          |                            | dep_count, file_count, entry_size,
//          |                            | entry_offset, entry_index
//
// One byte per cycle while byte_stall is low; the result register loads when a byte
// advances from the input register through the step logic, which sets that pace.
// rst_n clears the parser to the header phase; start_req does the same for its byte.
// A held result stalls only bytes that produce a result; silent bytes pass under it.
module pack_archive_index_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_in,
    input  logic        start_req,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [7:0]  char_out,
    output logic        version,
    output logic [31:0] archive_type,
    output logic [31:0] dep_count,
    output logic [31:0] file_count,
    output logic [31:0] entry_size,
    output logic [63:0] entry_offset,
    output logic [31:0] entry_index
);
    import pap_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_res;
    logic       out_free;
    logic       advance;
    logic       accept;

    pap_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .byte_in   (s1_byte_reg),
        .start_req (s1_start_reg),
        .res       (step_res)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && (out_free || !step_res.valid);
    assign byte_stall = s1_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= byte_in;
            s1_start_reg <= start_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && step_res.valid)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    // load only when the slot is free, so a stalled word holds
    always_ff @(posedge clk)
    begin
        if (advance && step_res.valid)
            out_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_reg.kind;
    assign char_out     = out_reg.char_out;
    assign version      = out_reg.version;
    assign archive_type = out_reg.archive_type;
    assign dep_count    = out_reg.dep_count;
    assign file_count   = out_reg.file_count;
    assign entry_size   = out_reg.entry_size;
    assign entry_offset = out_reg.entry_offset;
    assign entry_index  = out_reg.entry_index;

endmodule

// ===== design/pap_checker.sv =====
// Port-level checks for the pack archive index parser, bound to the top level.
// Depends on pap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  kind,
    input logic [7:0]  char_out,
    input logic        version,
    input logic [31:0] archive_type,
    input logic [31:0] dep_count,
    input logic [31:0] file_count,
    input logic [31:0] entry_size,
    input logic [63:0] entry_offset
);
    import pap_pkg::*;

    `PAP_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

    `PAP_ASSERT_NOW(a_path_no_bslash, result_valid && kind == KIND_PATH_CHAR,
        char_out != CHAR_BSLASH)

    `PAP_ASSERT_NOW(a_hdr_fields_zero, result_valid && kind != KIND_HEADER,
        version == 1'b0 && archive_type == 32'd0 && dep_count == 32'd0 && file_count == 32'd0)

    `PAP_ASSERT_NOW(a_entry_fields_zero, result_valid && kind != KIND_ENTRY,
        entry_size == 32'd0 && entry_offset == 64'd0)

endmodule

bind pack_archive_index_parser pap_checker u_pap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .char_out     (char_out),
    .version      (version),
    .archive_type (archive_type),
    .dep_count    (dep_count),
    .file_count   (file_count),
    .entry_size   (entry_size),
    .entry_offset (entry_offset)
);
